FILE: rtl/brrq_pkg.sv
// Package for the banked round-robin queue.
// Holds default sizes, request codes, controller states and the remainder-unit status.
// No dependencies.
package brrq_pkg;

    localparam int BANKS_DEF      = 16;
    localparam int BANK_DEPTH_DEF = 256;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CFG_W       = 9;
    localparam int CAP_RESET   = 256;
    localparam int BANK_OUT_W  = 4;
    localparam int TOTAL_OUT_W = 13;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_POP
    } brrq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } brrq_mod_status_t;

endpackage

FILE: rtl/brrq_ifs.sv
// Channel interfaces of the banked round-robin queue: request, response, capacity write.
// Depends on brrq_pkg.
interface brrq_req_if #(
    parameter int DATA_WIDTH = brrq_pkg::DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [DATA_WIDTH-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface brrq_rsp_if #(
    parameter int DATA_WIDTH = brrq_pkg::DATA_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic [DATA_WIDTH-1:0]              pop_value;
    logic [brrq_pkg::BANK_OUT_W-1:0]    bank_used;
    logic [brrq_pkg::TOTAL_OUT_W-1:0]   total_after;

    modport source (output valid, output ok, output pop_value, output bank_used,
                    output total_after, input ready);
    modport sink   (input valid, input ok, input pop_value, input bank_used,
                    input total_after, output ready);
endinterface

interface brrq_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [brrq_pkg::CFG_W-1:0] bank_capacity;

    modport source (output valid, output bank_capacity, input ready);
    modport sink   (input valid, input bank_capacity, output ready);
endinterface

FILE: rtl/brrq_mod.sv
// Bit-serial remainder unit: dividend modulo divisor, one dividend bit per cycle.
// Depends on brrq_pkg.
module brrq_mod #(
    parameter int BANK_DEPTH = brrq_pkg::BANK_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [$clog2(BANK_DEPTH+1):0]          dividend,
    input  logic [$clog2(BANK_DEPTH+1)-1:0]        divisor,
    output brrq_pkg::brrq_mod_status_t             status,
    output logic [$clog2(BANK_DEPTH)-1:0]          remainder
);
    import brrq_pkg::*;

    localparam int FW = $clog2(BANK_DEPTH + 1);
    localparam int HW = $clog2(BANK_DEPTH);
    localparam int SW = FW + 1;
    localparam int CW = $clog2(SW + 1);

    logic [SW-1:0] shift_reg, shift_next;
    logic [FW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [FW:0]   trial;

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, shift_reg[SW-1]};
        if (trial >= {1'b0, divisor})
        begin
            trial = trial - {1'b0, divisor};
        end
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = CW'(SW);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[SW-2:0], 1'b0};
            rem_next   = FW'(trial);
            cnt_next   = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = HW'(rem_reg);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("remainder unit busy and done together");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("remainder unit did not start");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor))
        else $error("remainder not below divisor");

endmodule

FILE: rtl/banked_round_robin_queue.sv
// Top level of the banked round-robin queue.
// Depends on brrq_pkg, brrq_ifs and brrq_mod.
//
// A queue of BANKS ring buffers that share one element count.
// req carries one word per request: req_type selects push or pop, push_value the element.
// rsp returns one word per request: ok, pop_value, bank_used and total_after.
// cfg writes bank_capacity, the per-bank full threshold; it is always ready and must
// only be written while no request is outstanding.
// Response: a push or a failed pop answers in the cycle after acceptance; a successful pop
// answers after the registered read of the element memory, through the S_POP state.
// Throughput: one push per cycle while rsp is not stalled and no remainder is computed.
// After a successful pop no request is taken until S_POP has passed. A push whose slot
// wraps past the capacity more than once (only possible after the capacity was lowered
// while banks held data) holds the next request off while the remainder unit runs.
// Reset empties all banks, clears both pointers and sets the capacity to 256 (limited to
// BANK_DEPTH); the element memory is not cleared and needs no clearing pass.
// When rsp is stalled the result is held in the output register and req stays ready only
// in a cycle in which that register is being emptied.
module banked_round_robin_queue #(
    parameter int BANKS      = brrq_pkg::BANKS_DEF,
    parameter int BANK_DEPTH = brrq_pkg::BANK_DEPTH_DEF,
    parameter int DATA_WIDTH = brrq_pkg::DATA_WIDTH_DEF
) (
    input logic   clk,
    input logic   rst_n,
    brrq_req_if.sink   req,
    brrq_rsp_if.source rsp,
    brrq_cfg_if.sink   cfg
);
    import brrq_pkg::*;

    localparam int BW    = $clog2(BANKS);
    localparam int HW    = $clog2(BANK_DEPTH);
    localparam int FW    = $clog2(BANK_DEPTH + 1);
    localparam int SW    = FW + 1;
    localparam int TOTAL = BANKS * BANK_DEPTH;
    localparam int TW    = $clog2(TOTAL + 1);
    localparam int AW    = $clog2(TOTAL);

    function automatic logic [FW-1:0] eff_cap(input logic [CFG_W-1:0] v);
        logic [FW-1:0] c;
        if (v == '0)
        begin
            c = FW'(1);
        end
        else if (32'(v) > 32'(BANK_DEPTH))
        begin
            c = FW'(BANK_DEPTH);
        end
        else
        begin
            c = FW'(v);
        end
        return c;
    endfunction

    function automatic logic [BW:0] find_first(input logic [BANKS-1:0] flags,
                                               input logic [BW-1:0]    start_bank);
        logic [BANKS-1:0] hi;
        logic [BW-1:0]    idx_hi;
        logic [BW-1:0]    idx_lo;
        logic             f_hi;
        logic             f_lo;
        idx_hi = '0;
        idx_lo = '0;
        f_hi   = 1'b0;
        f_lo   = 1'b0;
        for (int i = 0; i < BANKS; i++)
        begin
            hi[i] = flags[i] && (BW'(i) >= start_bank);
        end
        for (int i = BANKS - 1; i >= 0; i--)
        begin
            if (hi[i])
            begin
                f_hi   = 1'b1;
                idx_hi = BW'(i);
            end
            if (flags[i])
            begin
                f_lo   = 1'b1;
                idx_lo = BW'(i);
            end
        end
        return f_hi ? {1'b1, idx_hi} : {f_lo, idx_lo};
    endfunction

    function automatic logic [BW-1:0] next_bank(input logic [BW-1:0] b);
        return (b == BW'(BANKS - 1)) ? '0 : b + BW'(1);
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [BW-1:0] b,
                                               input logic [HW-1:0] s);
        return AW'(b) * AW'(BANK_DEPTH) + AW'(s);
    endfunction

    brrq_state_t state_reg, state_next;

    logic [HW-1:0] head_reg [BANKS];
    logic [HW-1:0] head_next [BANKS];
    logic [FW-1:0] fill_reg [BANKS];
    logic [FW-1:0] fill_next [BANKS];
    logic [TW-1:0] total_reg, total_next;
    logic [BW-1:0] enq_ptr_reg, enq_ptr_next;
    logic [BW-1:0] deq_ptr_reg, deq_ptr_next;
    logic [FW-1:0] cap_reg;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  rsp_ok_reg, rsp_ok_next;
    logic [DATA_WIDTH-1:0] rsp_value_reg, rsp_value_next;
    logic [BW-1:0]         rsp_bank_reg, rsp_bank_next;
    logic [TW-1:0]         rsp_total_reg, rsp_total_next;

    logic [BW-1:0]         pend_bank_reg, pend_bank_next;
    logic [DATA_WIDTH-1:0] pend_data_reg, pend_data_next;

    logic [DATA_WIDTH-1:0] elem_mem [TOTAL];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [BW-1:0]         mem_wbank;
    logic [HW-1:0]         mem_wslot;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;

    logic [BANKS-1:0] push_flags;
    logic [BANKS-1:0] pop_flags;
    logic [BW:0]      push_find;
    logic [BW:0]      pop_find;
    logic             push_hit;
    logic [BW-1:0]    push_bank;
    logic             pop_hit;
    logic [BW-1:0]    pop_bank;
    logic [SW-1:0]    push_sum;
    logic [SW-1:0]    cap_sw;
    logic [SW:0]      cap_x2;
    logic [FW-1:0]    pop_head_inc;
    logic             req_fire;

    logic             mod_start;
    brrq_mod_status_t mod_st;
    logic [HW-1:0]    mod_rem;

    brrq_mod #(
        .BANK_DEPTH (BANK_DEPTH)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (push_sum),
        .divisor   (cap_reg),
        .status    (mod_st),
        .remainder (mod_rem)
    );

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            push_flags[b] = fill_reg[b] < cap_reg;
            pop_flags[b]  = fill_reg[b] != '0;
        end
    end

    assign push_find    = find_first(push_flags, enq_ptr_reg);
    assign pop_find     = find_first(pop_flags, deq_ptr_reg);
    assign push_hit     = push_find[BW];
    assign push_bank    = push_find[BW-1:0];
    assign pop_hit      = pop_find[BW];
    assign pop_bank     = pop_find[BW-1:0];
    assign push_sum     = SW'(head_reg[push_bank]) + SW'(fill_reg[push_bank]);
    assign cap_sw       = SW'(cap_reg);
    assign cap_x2       = {1'b0, cap_reg, 1'b0};
    assign pop_head_inc = FW'(head_reg[pop_bank]) + FW'(1);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        enq_ptr_next   = enq_ptr_reg;
        deq_ptr_next   = deq_ptr_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_ok_next    = rsp_ok_reg;
        rsp_value_next = rsp_value_reg;
        rsp_bank_next  = rsp_bank_reg;
        rsp_total_next = rsp_total_reg;
        pend_bank_next = pend_bank_reg;
        pend_data_next = pend_data_reg;
        mem_we         = 1'b0;
        mem_wbank      = push_bank;
        mem_wslot      = HW'(push_sum);
        mem_wdata      = req.push_value;
        mem_re         = 1'b0;
        mem_raddr      = mem_addr(pop_bank, head_reg[pop_bank]);
        mod_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == REQ_PUSH)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_ok_next    = push_hit;
                        rsp_value_next = '0;
                        rsp_bank_next  = push_hit ? push_bank : '0;
                        rsp_total_next = total_reg;
                        if (push_hit)
                        begin
                            fill_next[push_bank] = fill_reg[push_bank] + FW'(1);
                            total_next     = total_reg + TW'(1);
                            rsp_total_next = total_reg + TW'(1);
                            enq_ptr_next   = next_bank(push_bank);
                            if (push_sum < cap_sw)
                            begin
                                mem_we = 1'b1;
                            end
                            else if ((SW+1)'(push_sum) < cap_x2)
                            begin
                                mem_we    = 1'b1;
                                mem_wslot = HW'(push_sum - cap_sw);
                            end
                            else
                            begin
                                mod_start      = 1'b1;
                                pend_bank_next = push_bank;
                                pend_data_next = req.push_value;
                                state_next     = S_MOD;
                            end
                        end
                    end
                    else if (pop_hit)
                    begin
                        mem_re = 1'b1;
                        head_next[pop_bank] = (pop_head_inc >= cap_reg) ? '0 : HW'(pop_head_inc);
                        fill_next[pop_bank] = fill_reg[pop_bank] - FW'(1);
                        total_next     = total_reg - TW'(1);
                        deq_ptr_next   = next_bank(pop_bank);
                        pend_bank_next = pop_bank;
                        state_next     = S_POP;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_ok_next    = 1'b0;
                        rsp_value_next = '0;
                        rsp_bank_next  = '0;
                        rsp_total_next = total_reg;
                    end
                end
            end
            S_MOD:
            begin
                mem_wbank = pend_bank_reg;
                mem_wslot = mod_rem;
                mem_wdata = pend_data_reg;
                if (mod_st.done)
                begin
                    mem_we     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                rsp_valid_next = 1'b1;
                rsp_ok_next    = 1'b1;
                rsp_value_next = rd_data_reg;
                rsp_bank_next  = pend_bank_reg;
                rsp_total_next = total_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            enq_ptr_reg   <= '0;
            deq_ptr_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            cap_reg       <= eff_cap(CFG_W'(CAP_RESET));
            for (int b = 0; b < BANKS; b++)
            begin
                head_reg[b] <= '0;
                fill_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            enq_ptr_reg   <= enq_ptr_next;
            deq_ptr_reg   <= deq_ptr_next;
            rsp_valid_reg <= rsp_valid_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= eff_cap(cfg.bank_capacity);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_ok_reg    <= rsp_ok_next;
        rsp_value_reg <= rsp_value_next;
        rsp_bank_reg  <= rsp_bank_next;
        rsp_total_reg <= rsp_total_next;
        pend_bank_reg <= pend_bank_next;
        pend_data_reg <= pend_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            elem_mem[mem_addr(mem_wbank, mem_wslot)] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= elem_mem[mem_raddr];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.pop_value   = rsp_value_reg;
    assign rsp.bank_used   = BANK_OUT_W'(rsp_bank_reg);
    assign rsp.total_after = TOTAL_OUT_W'(rsp_total_reg);

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (rsp_valid_reg || state_reg == S_POP || state_reg == S_MOD))
        else $error("accepted request produced no progress");

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> !rsp_valid_reg)
        else $error("pop read finished while output register occupied");

    a_mod_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (mod_st.busy || mod_st.done))
        else $error("waiting on idle remainder unit");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(TOTAL))
        else $error("element count beyond queue size");

endmodule

FILE: test/brrq_checker.sv
// Response checker for the banked round-robin queue: watches the request, response and
// capacity channels, predicts every response word and compares it field by field.
// Depends on brrq_pkg and the channel interfaces in brrq_ifs.
`timescale 1ns / 100ps

module brrq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    brrq_req_if                                req,
    brrq_rsp_if                                rsp,
    brrq_cfg_if                                cfg,
    output int                                 errors,
    output int                                 pending,
    output logic [brrq_pkg::TOTAL_OUT_W-1:0]   held_total
);

    localparam int NB     = brrq_pkg::BANKS_DEF;
    localparam int DEPTH  = brrq_pkg::BANK_DEPTH_DEF;
    localparam int DW     = brrq_pkg::DATA_WIDTH_DEF;
    localparam int HEAD_W = $clog2(DEPTH);

    typedef struct packed {
        logic                               ok;
        logic [DW-1:0]                      value;
        logic [brrq_pkg::BANK_OUT_W-1:0]    bank;
        logic [brrq_pkg::TOTAL_OUT_W-1:0]   total;
    } queue_answer_t;

    logic [DW-1:0]                      element_mem [NB][DEPTH];
    logic [HEAD_W-1:0]                  head_idx [NB];
    logic [brrq_pkg::CFG_W-1:0]         fill_cnt [NB];
    logic [brrq_pkg::TOTAL_OUT_W-1:0]   total_cnt;
    logic [brrq_pkg::BANK_OUT_W-1:0]    enq_ptr;
    logic [brrq_pkg::BANK_OUT_W-1:0]    deq_ptr;
    logic [brrq_pkg::CFG_W-1:0]         capacity;
    queue_answer_t                      owed_answers [$];

    function automatic queue_answer_t serve_request(logic kind, logic [DW-1:0] value);
        queue_answer_t ans;
        int lim;
        int b;
        int k;
        int slot;
        bit found;
        lim = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : int'(capacity));
        ans = '0;
        found = 1'b0;
        if (kind == brrq_pkg::REQ_PUSH) begin
            b = int'(enq_ptr);
            for (k = 0; k < NB && !found; k++) begin
                if (fill_cnt[b] < lim)
                    found = 1'b1;
                else
                    b = (b + 1) % NB;
            end
            if (found) begin
                slot = (int'(head_idx[b]) + int'(fill_cnt[b])) % lim;
                element_mem[b][slot] = value;
                fill_cnt[b] = fill_cnt[b] + 1'b1;
                total_cnt = total_cnt + 1'b1;
                enq_ptr = 4'((b + 1) % NB);
                ans.ok = 1'b1;
                ans.bank = 4'(b);
            end
        end else if (total_cnt != 0) begin
            b = int'(deq_ptr);
            for (k = 0; k < NB && !found; k++) begin
                if (fill_cnt[b] != 0)
                    found = 1'b1;
                else
                    b = (b + 1) % NB;
            end
            if (found) begin
                ans.value = element_mem[b][head_idx[b]];
                head_idx[b] = (int'(head_idx[b]) + 1 >= lim) ? '0 : head_idx[b] + 1'b1;
                fill_cnt[b] = fill_cnt[b] - 1'b1;
                total_cnt = total_cnt - 1'b1;
                deq_ptr = 4'((b + 1) % NB);
                ans.ok = 1'b1;
                ans.bank = 4'(b);
            end
        end
        ans.total = total_cnt;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        queue_answer_t seen;
        queue_answer_t want;
        int i;
        if (!rst_n) begin
            for (i = 0; i < NB; i++) begin
                head_idx[i] = '0;
                fill_cnt[i] = '0;
            end
            total_cnt = '0;
            enq_ptr = '0;
            deq_ptr = '0;
            capacity = brrq_pkg::CFG_W'(brrq_pkg::CAP_RESET);
            owed_answers.delete();
            errors = 0;
            pending = 0;
            held_total = '0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                seen = {rsp.ok, rsp.pop_value, rsp.bank_used, rsp.total_after};
                if (owed_answers.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected response word: ok=%0d value=%h bank=%0d total=%0d",
                                 seen.ok, seen.value, seen.bank, seen.total);
                end else begin
                    want = owed_answers.pop_front();
                    if (seen.ok !== want.ok || seen.value !== want.value ||
                        seen.bank !== want.bank || seen.total !== want.total) begin
                        errors++;
                        if (errors <= 10)
                            $display({"response mismatch: expected ok=%0d value=%h bank=%0d ",
                                      "total=%0d, got ok=%0d value=%h bank=%0d total=%0d"},
                                     want.ok, want.value, want.bank, want.total,
                                     seen.ok, seen.value, seen.bank, seen.total);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                capacity = cfg.bank_capacity;
            if (req.valid && req.ready)
                owed_answers.push_back(serve_request(req.req_type, req.push_value));
            pending = owed_answers.size();
            held_total = total_cnt;
        end
    end

endmodule

FILE: test/tb_banked_round_robin_queue.sv
// Testbench top for the banked round-robin queue: clock, reset, request and capacity
// stimulus under several idling patterns, and the verdict.
// Depends on brrq_pkg, brrq_ifs, the queue RTL and brrq_checker.
`timescale 1ns / 100ps

module tb_banked_round_robin_queue;

    localparam int NB          = brrq_pkg::BANKS_DEF;
    localparam int PREFILL_CAP = 8;
    localparam int PHASES      = 16;
    localparam int PHASE_WORDS = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   errors;
    int   pending;
    logic [brrq_pkg::TOTAL_OUT_W-1:0] held_total;

    // small entries keep the slots in use inside the prefilled range; large ones start empty
    logic [brrq_pkg::CFG_W-1:0] phase_caps [PHASES] = '{
        9'd1, 9'd0, 9'd2, 9'd511, 9'd8, 9'd3, 9'd256, 9'd5,
        9'd1, 9'd4, 9'd300, 9'd7, 9'd2, 9'd8, 9'd6, 9'd257
    };

    brrq_req_if req_ch ();
    brrq_rsp_if rsp_ch ();
    brrq_cfg_if cfg_ch ();

    banked_round_robin_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    brrq_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .errors     (errors),
        .pending    (pending),
        .held_total (held_total)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(input logic kind, input logic [31:0] value);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.push_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [brrq_pkg::CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.bank_capacity <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int p;
        int n;
        int push_pct;
        logic [brrq_pkg::CFG_W-1:0] cap;

        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= brrq_pkg::REQ_PUSH;
        req_ch.push_value <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.bank_capacity <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(brrq_pkg::REQ_POP, 32'h1234_5678);
        send_word(brrq_pkg::REQ_PUSH, 32'h0000_0000);
        send_word(brrq_pkg::REQ_PUSH, 32'hFFFF_FFFF);
        send_word(brrq_pkg::REQ_PUSH, 32'hAAAA_AAAA);
        send_word(brrq_pkg::REQ_PUSH, 32'h5555_5555);
        repeat (5) send_word(brrq_pkg::REQ_POP, $urandom);
        settle();

        // fill every bank to the small capacity, then overflow it
        write_capacity(9'(PREFILL_CAP));
        repeat (NB * PREFILL_CAP + 2) send_word(brrq_pkg::REQ_PUSH, $urandom);

        for (p = 0; p < PHASES; p++)
        begin
            cap = phase_caps[p];
            settle();
            if (cap <= PREFILL_CAP)
            begin
                // leave no bank empty before the capacity moves
                repeat (NB) send_word(brrq_pkg::REQ_PUSH, $urandom);
            end
            else
            begin
                n = int'(held_total);
                repeat (n) send_word(brrq_pkg::REQ_POP, $urandom);
            end
            settle();
            write_capacity(cap);
            gap_pct <= (p % 4 == 1) ? 50 : ((p % 4 == 3) ? 28 : 0);
            stall_pct <= (p % 4 == 2) ? 50 : ((p % 4 == 3) ? 28 : 0);
            push_pct = (p % 3 == 0) ? 65 : ((p % 3 == 1) ? 35 : 50);
            repeat (PHASE_WORDS)
                send_word(($urandom_range(99) < push_pct) ? brrq_pkg::REQ_PUSH
                                                          : brrq_pkg::REQ_POP, $urandom);
        end
        settle();

        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
